### rtl/assert_macros.svh
// Assertion helpers shared by ihc_accum.sv and ihc_outbuf.sv. Each macro expects the module
// to have the clock aclk and the active-low synchronous reset aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IHC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define IHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ihc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ihc_pkg;

    // Header byte positions.
    localparam int IDX_PROTOCOL = 9;
    localparam int IDX_CSUM_HI  = 10;
    localparam int IDX_CSUM_LO  = 11;
    localparam int IDX_DST_0    = 16;
    localparam int IDX_DST_1    = 17;
    localparam int IDX_DST_2    = 18;
    localparam int IDX_DST_3    = 19;

    // Protocol number of ICMP.
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // Own address after reset: 192.168.1.20.
    localparam logic [31:0] OWN_ADDR_RESET = 32'hC0A8_0114;

    // One result word, first field in the highest bits.
    typedef struct packed {
        logic [15:0] computed_checksum;
        logic [15:0] received_checksum;
        logic        checksum_ok;
        logic        for_me_icmp;
    } ihc_result_t;

    localparam int RES_W     = $bits(ihc_result_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int S_TDATA_W = 8;

    // 16-bit ones'-complement add with the carry folded back in.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

`default_nettype wire

### rtl/ihc_accum.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ihc_accum #(
    parameter int HEADER_BYTES = 20
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_fire,
    input  wire logic [7:0]          data_byte,
    input  wire logic                first_byte,
    input  wire logic [31:0]         own_address,
    output logic                     res_valid,
    output ihc_pkg::ihc_result_t     res
);
    import ihc_pkg::*;

    localparam int CW = $clog2(HEADER_BYTES + 1);
    localparam logic [CW-1:0] HDR_LEN  = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] HDR_LAST = CW'(HEADER_BYTES - 1);

    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    hold_reg, hold_next;
    logic [15:0]   capt_reg, capt_next;
    logic          addr_match_reg, addr_match_next;
    logic          proto_match_reg, proto_match_next;

    logic [CW-1:0] idx;
    logic [15:0]   eff_sum;
    logic [7:0]    eff_hold;
    logic [15:0]   eff_capt;
    logic          eff_addr;
    logic          eff_proto;
    logic          in_hdr;
    logic          is_dst;
    logic [7:0]    want_byte;
    logic [7:0]    sb;
    logic [15:0]   add_word;
    logic [15:0]   sum_add;
    logic [15:0]   computed;

    // A first-byte flag restarts the header from a clean state.
    always_comb begin
        idx       = first_byte ? '0     : count_reg;
        eff_sum   = first_byte ? 16'd0  : sum_reg;
        eff_hold  = first_byte ? 8'd0   : hold_reg;
        eff_capt  = first_byte ? 16'd0  : capt_reg;
        eff_addr  = first_byte ? 1'b1   : addr_match_reg;
        eff_proto = first_byte ? 1'b0   : proto_match_reg;
        in_hdr    = (idx < HDR_LEN);
    end

    // Destination byte that the current position should carry.
    always_comb begin
        is_dst    = 1'b1;
        want_byte = 8'd0;
        case (idx)
            CW'(IDX_DST_0): want_byte = own_address[31:24];
            CW'(IDX_DST_1): want_byte = own_address[23:16];
            CW'(IDX_DST_2): want_byte = own_address[15:8];
            CW'(IDX_DST_3): want_byte = own_address[7:0];
            default:        is_dst    = 1'b0;
        endcase
    end

    // One ones'-complement adder serves both the word sum and the odd-length tail.
    always_comb begin
        sb = ((idx == CW'(IDX_CSUM_HI)) || (idx == CW'(IDX_CSUM_LO))) ? 8'd0 : data_byte;
        add_word = idx[0] ? {eff_hold, sb} : {sb, 8'd0};
        sum_add  = ones_add(eff_sum, add_word);
        computed = ~sum_add;
    end

    // Next state of the header accumulators.
    always_comb begin
        count_next       = idx;
        sum_next         = eff_sum;
        hold_next        = eff_hold;
        capt_next        = eff_capt;
        addr_match_next  = eff_addr;
        proto_match_next = eff_proto;
        if (in_hdr) begin
            count_next = idx + CW'(1);
            if (idx == CW'(IDX_PROTOCOL)) begin
                proto_match_next = (data_byte == PROTO_ICMP);
            end
            if (is_dst && (data_byte != want_byte)) begin
                addr_match_next = 1'b0;
            end
            if (idx == CW'(IDX_CSUM_HI)) begin
                capt_next[15:8] = data_byte;
            end
            if (idx == CW'(IDX_CSUM_LO)) begin
                capt_next[7:0] = data_byte;
            end
            if (idx[0]) begin
                sum_next  = sum_add;
                hold_next = 8'd0;
            end else begin
                hold_next = sb;
            end
        end
    end

    // Result on the last header byte.
    always_comb begin
        res_valid             = in_fire && (idx == HDR_LAST);
        res.for_me_icmp       = addr_match_next && proto_match_next;
        res.received_checksum = capt_next;
        res.computed_checksum = computed;
        res.checksum_ok       = (capt_next == computed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            sum_reg         <= 16'd0;
            hold_reg        <= 8'd0;
            capt_reg        <= 16'd0;
            addr_match_reg  <= 1'b1;
            proto_match_reg <= 1'b0;
        end else if (in_fire) begin
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            hold_reg        <= hold_next;
            capt_reg        <= capt_next;
            addr_match_reg  <= addr_match_next;
            proto_match_reg <= proto_match_next;
        end
    end

    `IHC_ASSERT_ALWAYS(a_count_saturates, count_reg <= HDR_LEN)
    `IHC_ASSERT_NEXT(a_result_ends_header, res_valid, count_reg == HDR_LEN)

endmodule

`default_nettype wire

### rtl/ihc_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ihc_outbuf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 res_valid,
    input  wire ihc_pkg::ihc_result_t res,
    output logic                      in_ready,
    output logic                      out_valid,
    output ihc_pkg::ihc_result_t      out_word,
    input  wire logic                 out_ready
);
    import ihc_pkg::*;

    logic        main_valid_reg, main_valid_next;
    ihc_result_t main_reg, main_next;
    logic        skid_valid_reg, skid_valid_next;
    ihc_result_t skid_reg, skid_next;
    logic        pop;

    // Input side stalls only once both the output and skid stages are full.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    // Output stage and skid stage control.
    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = res_valid;
                main_next       = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `IHC_ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_reg || main_valid_reg)
    `IHC_ASSERT_NEXT(a_stalled_word_to_skid, main_valid_reg && !out_ready && res_valid, skid_valid_reg)

endmodule

`default_nettype wire

### rtl/ipv4_icmp_header_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// IPv4 header checker for ICMP traffic. Packet bytes enter on the s_ stream
// one word per clock while s_tready is high, with s_tuser marking the first
// byte of a packet. Over the first HEADER_BYTES bytes the block compares the
// destination address with own_address (set through cfg_wr_en / cfg_wr_data,
// 192.168.1.20 after reset), checks for protocol ICMP, captures the received
// checksum and sums the header in ones'-complement with the checksum field
// taken as zero. On the last header byte one result word is formed for the
// m_ stream; later bytes are dropped until the next first byte. The single
// end-around-carry adder sits between the header state and the output
// register, so a byte is accepted every cycle unless s_tready is low, and
// the result word is registered before it leaves. The two-word output stage
// lets input keep flowing while one result waits; the input stalls only when two
// results are held. Write own_address only while no packet is in flight.
module ipv4_icmp_header_checker #(
    parameter int HEADER_BYTES = 20
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration: own IPv4 address, first address byte in bits 31:24.
    input  wire logic                            cfg_wr_en,
    input  wire logic [31:0]                     cfg_wr_data,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ihc_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tuser,   // [0] first_byte
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] for_me_icmp, [1] checksum_ok, [17:2] received_checksum,
    // [33:18] computed_checksum, upper bits zero
    output logic [ihc_pkg::M_TDATA_W-1:0]        m_tdata
);
    import ihc_pkg::*;

    logic [31:0] own_addr_reg;
    logic        in_fire;
    logic        res_valid;
    ihc_result_t res;
    ihc_result_t out_word;

    // Own address register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= OWN_ADDR_RESET;
        end else if (cfg_wr_en) begin
            own_addr_reg <= cfg_wr_data;
        end
    end

    assign in_fire = s_tvalid && s_tready;

    ihc_accum #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_tdata[7:0]),
        .first_byte  (s_tuser),
        .own_address (own_addr_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    ihc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_word  (out_word),
        .out_ready (m_tready)
    );

    // Zero-fill the result word up to whole bytes.
    assign m_tdata = M_TDATA_W'(out_word);

endmodule

`default_nettype wire

### verif/ipv4_icmp_header_checker_tb.sv
`timescale 1ns / 1ps

module ipv4_icmp_header_checker_tb;

    import ihc_pkg::*;

    localparam int          HDR_LEN     = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } pkt_byte_t;

    typedef logic [7:0] header_t [HDR_LEN];

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [31:0]            cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [7:0] data_byte
    logic                   s_tuser;    // [0] first_byte
    logic                   m_tvalid;
    logic                   m_tready;
    // [0] for_me_icmp, [1] checksum_ok, [17:2] received_checksum,
    // [33:18] computed_checksum, upper bits zero
    logic [M_TDATA_W-1:0]   m_tdata;

    // Bytes waiting to be sent and header results waiting to come back.
    pkt_byte_t    packet_bytes[$];
    ihc_result_t  pending_results[$];

    // Idling controls, set by the sequence and read by driver and monitor.
    int unsigned  tx_idle_pct;
    int unsigned  rx_stall_pct;
    logic         rx_hold;

    int unsigned  err_cnt;
    int unsigned  cycle_cnt;

    // Predicted header state of the block.
    logic [31:0]  own_addr_cfg = OWN_ADDR_RESET;
    logic [5:0]   hdr_count    = '0;
    logic [15:0]  sum_acc      = '0;
    logic [7:0]   hi_hold      = '0;
    logic [15:0]  csum_cap     = '0;
    logic         addr_ok      = 1'b1;
    logic         proto_ok     = 1'b0;

    ipv4_icmp_header_checker #(
        .HEADER_BYTES (HDR_LEN)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // 16-bit ones'-complement add with end-around carry.
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Fills the checksum bytes so that the header verifies.
    function automatic header_t set_checksum(input header_t hdr);
        logic [15:0] s;
        s = '0;
        hdr[IDX_CSUM_HI] = 8'h00;
        hdr[IDX_CSUM_LO] = 8'h00;
        for (int i = 0; i < HDR_LEN; i += 2) begin
            s = fold_add(s, {hdr[i], (i + 1 < HDR_LEN) ? hdr[i + 1] : 8'h00});
        end
        s = ~s;
        hdr[IDX_CSUM_HI] = s[15:8];
        hdr[IDX_CSUM_LO] = s[7:0];
        return hdr;
    endfunction

    // Random header; destination, protocol and checksum made valid on request.
    function automatic header_t build_header(input logic [31:0] addr, input bit good_dest,
                                             input bit good_proto, input bit good_csum);
        header_t     hdr;
        logic [31:0] dst;
        for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'($urandom_range(0, 255));
        if ($urandom_range(1, 4) != 1) hdr[0] = 8'h45;
        dst = addr;
        if (!good_dest) begin
            if ($urandom_range(0, 1) == 1)
                dst = addr ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
            else
                dst = $urandom;
        end
        hdr[IDX_DST_0] = dst[31:24];
        hdr[IDX_DST_1] = dst[23:16];
        hdr[IDX_DST_2] = dst[15:8];
        hdr[IDX_DST_3] = dst[7:0];
        if (good_proto) hdr[IDX_PROTOCOL] = PROTO_ICMP;
        if (good_csum) hdr = set_checksum(hdr);
        return hdr;
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic f);
        pkt_byte_t pb;
        pb.data  = d;
        pb.first = f;
        packet_bytes.push_back(pb);
    endtask

    // Queues the first keep header bytes followed by tail payload bytes.
    task automatic push_header(input header_t hdr, input bit lead_first,
                               input int unsigned keep, input int unsigned tail);
        for (int i = 0; i < keep; i++) push_byte(hdr[i], (i == 0) && lead_first);
        for (int i = 0; i < tail; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Mostly complete packets, with truncated ones, unflagged ones and noise.
    task automatic gen_traffic(input int unsigned n_items);
        int unsigned made;
        int unsigned kind;
        int unsigned cnt;
        header_t     hdr;
        made = 0;
        while (made < n_items) begin
            kind = $urandom_range(0, 99);
            hdr  = build_header(own_addr_cfg, $urandom_range(0, 9) != 0,
                                $urandom_range(0, 9) != 0, $urandom_range(0, 1) == 1);
            if (kind < 75) begin
                push_header(hdr, 1'b1, HDR_LEN, $urandom_range(0, 5));
                made += HDR_LEN;
            end else if (kind < 85) begin
                cnt = $urandom_range(1, HDR_LEN - 1);
                push_header(hdr, 1'b1, cnt, 0);
                made += cnt;
            end else if (kind < 93) begin
                push_header(hdr, 1'b0, HDR_LEN, $urandom_range(0, 3));
                made += HDR_LEN;
            end else begin
                cnt = $urandom_range(1, 8);
                for (int i = 0; i < cnt; i++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                made += cnt;
            end
        end
        // Close with a whole header so the block sits idle afterwards.
        hdr = build_header(own_addr_cfg, 1'b1, 1'b1, 1'b1);
        push_header(hdr, 1'b1, HDR_LEN, 0);
    endtask

    // Predicts the effect of one accepted byte; queues a result on the last header byte.
    task automatic predict_header_byte(input logic [7:0] b, input logic first);
        logic [5:0]  idx;
        logic [7:0]  sb;
        logic [15:0] fin;
        ihc_result_t r;
        if (first) begin
            hdr_count = '0;
            sum_acc   = '0;
            hi_hold   = '0;
            csum_cap  = '0;
            addr_ok   = 1'b1;
            proto_ok  = 1'b0;
        end
        idx = hdr_count;
        if (idx < HDR_LEN) begin
            if (idx == IDX_PROTOCOL) proto_ok = (b == PROTO_ICMP);
            if (idx >= IDX_DST_0 && idx <= IDX_DST_3) begin
                if (b != 8'(own_addr_cfg >> (8 * (IDX_DST_3 - idx)))) addr_ok = 1'b0;
            end
            if (idx == IDX_CSUM_HI) csum_cap[15:8] = b;
            if (idx == IDX_CSUM_LO) csum_cap[7:0] = b;
            sb = (idx == IDX_CSUM_HI || idx == IDX_CSUM_LO) ? 8'h00 : b;
            if (!idx[0]) begin
                hi_hold = sb;
            end else begin
                sum_acc = fold_add(sum_acc, {hi_hold, sb});
                hi_hold = '0;
            end
            hdr_count = idx + 6'd1;
            if (idx == HDR_LEN - 1) begin
                fin = sum_acc;
                if (!idx[0]) fin = fold_add(fin, {sb, 8'h00});
                r.computed_checksum = ~fin;
                r.received_checksum = csum_cap;
                r.checksum_ok       = (csum_cap == ~fin);
                r.for_me_icmp       = addr_ok && proto_ok;
                pending_results.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch in %s: got %h, want %h", what, got, want);
        err_cnt++;
    endtask

    // Compares one accepted result word with the oldest prediction.
    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        ihc_result_t got;
        ihc_result_t want;
        got = ihc_result_t'(word[RES_W-1:0]);
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word", 40'(word), 40'd0);
        end else begin
            want = pending_results.pop_front();
            if (got.for_me_icmp != want.for_me_icmp)
                report_mismatch("for_me_icmp", 40'(got.for_me_icmp), 40'(want.for_me_icmp));
            if (got.checksum_ok != want.checksum_ok)
                report_mismatch("checksum_ok", 40'(got.checksum_ok), 40'(want.checksum_ok));
            if (got.received_checksum != want.received_checksum)
                report_mismatch("received_checksum", 40'(got.received_checksum),
                                40'(want.received_checksum));
            if (got.computed_checksum != want.computed_checksum)
                report_mismatch("computed_checksum", 40'(got.computed_checksum),
                                40'(want.computed_checksum));
            if ((word >> RES_W) != '0)
                report_mismatch("padding bits", 40'(word >> RES_W), 40'd0);
        end
    endtask

    // Driver: predicts each accepted word and offers the next byte from the queue.
    always @(posedge aclk) begin
        pkt_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_header_byte(s_tdata[7:0], s_tuser);
            if (!s_tvalid || s_tready) begin
                if (packet_bytes.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = packet_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word and stalls at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Run limit.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Waits until every byte is sent and every result is back, then lets the block settle.
    task automatic wait_drained();
        @(negedge aclk);
        while (packet_bytes.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_own_addr(input logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= v;
        own_addr_cfg <= v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        @(posedge aclk);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
        @(negedge aclk);
    endtask

    initial begin
        header_t hdr;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 1'b0;
        err_cnt      = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Header right after reset with no first flag, all-ones bytes, a byte past
        // the header, then a packet cut short after three bytes.
        for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'hFF;
        hdr[IDX_PROTOCOL] = PROTO_ICMP;
        hdr[IDX_DST_0]    = OWN_ADDR_RESET[31:24];
        hdr[IDX_DST_1]    = OWN_ADDR_RESET[23:16];
        hdr[IDX_DST_2]    = OWN_ADDR_RESET[15:8];
        hdr[IDX_DST_3]    = OWN_ADDR_RESET[7:0];
        hdr = set_checksum(hdr);
        push_header(hdr, 1'b0, HDR_LEN, 1);
        hdr = build_header(own_addr_cfg, 1'b1, 1'b1, 1'b1);
        push_header(hdr, 1'b1, 3, 0);

        // No idling, with a long receiver hold-off while bytes keep coming.
        gen_traffic(160);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
        wait_drained();

        // Sender idles; halfway it pauses until all results are back.
        write_own_addr(32'hFFFF_FFFF);
        set_idling(54, 0);
        gen_traffic(80);
        while (packet_bytes.size() != 0 || s_tvalid) @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
        gen_traffic(80);
        wait_drained();

        // Receiver stalls.
        write_own_addr(32'h0000_0000);
        set_idling(0, 54);
        gen_traffic(160);
        wait_drained();

        // Both sides idle now and then.
        write_own_addr($urandom);
        set_idling(7, 7);
        gen_traffic(160);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### ipv4_icmp_header_checker.f
+incdir+rtl
rtl/ihc_pkg.sv
rtl/ihc_accum.sv
rtl/ihc_outbuf.sv
rtl/ipv4_icmp_header_checker.sv
verif/ipv4_icmp_header_checker_tb.sv
